### src/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// class codes and state record for the grapheme cluster boundary detector
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int unsigned CLASS_W = 4;
    localparam int unsigned CONJ_W  = 2;

    // grapheme break classes
    localparam logic [CLASS_W-1:0] GC_OTHER   = 4'd0;
    localparam logic [CLASS_W-1:0] GC_CR      = 4'd1;
    localparam logic [CLASS_W-1:0] GC_LF      = 4'd2;
    localparam logic [CLASS_W-1:0] GC_CONTROL = 4'd3;
    localparam logic [CLASS_W-1:0] GC_EXTEND  = 4'd4;
    localparam logic [CLASS_W-1:0] GC_ZWJ     = 4'd5;
    localparam logic [CLASS_W-1:0] GC_RI      = 4'd6;
    localparam logic [CLASS_W-1:0] GC_PREPEND = 4'd7;
    localparam logic [CLASS_W-1:0] GC_SPACING = 4'd8;
    localparam logic [CLASS_W-1:0] GC_L       = 4'd9;
    localparam logic [CLASS_W-1:0] GC_V       = 4'd10;
    localparam logic [CLASS_W-1:0] GC_T       = 4'd11;
    localparam logic [CLASS_W-1:0] GC_LV      = 4'd12;
    localparam logic [CLASS_W-1:0] GC_LVT     = 4'd13;
    localparam logic [CLASS_W-1:0] GC_PICT    = 4'd14;

    // indic conjunct break classes
    localparam logic [CONJ_W-1:0] IC_NONE      = 2'd0;
    localparam logic [CONJ_W-1:0] IC_CONSONANT = 2'd1;
    localparam logic [CONJ_W-1:0] IC_EXTEND    = 2'd2;
    localparam logic [CONJ_W-1:0] IC_LINKER    = 2'd3;

    typedef struct packed {
        logic [CLASS_W-1:0] prior_class;
        logic               indicator_run_odd;
        logic               pictograph_open;
        logic               consonant_seen;
        logic               linker_after_consonant;
    } t_gcb_state;

    localparam t_gcb_state GCB_STATE_RESET = '{
        prior_class:            GC_OTHER,
        indicator_run_odd:      1'b0,
        pictograph_open:        1'b0,
        consonant_seen:         1'b0,
        linker_after_consonant: 1'b0
    };

endpackage

### src/gcb_in_if.sv
// ----------------------------------------------------------------------------
// gcb_in_if
// codepoint channel: valid/ready with classified codepoint payload
// ----------------------------------------------------------------------------
interface gcb_in_if;
    logic                        valid;
    logic                        ready;
    logic [gcb_pkg::CLASS_W-1:0] break_class;
    logic [gcb_pkg::CONJ_W-1:0]  conjunct_class;
    logic                        text_start;

    modport source (output valid, output break_class, output conjunct_class,
                    output text_start, input ready);
    modport sink   (input valid, input break_class, input conjunct_class,
                    input text_start, output ready);
endinterface

### src/gcb_out_if.sv
// ----------------------------------------------------------------------------
// gcb_out_if
// boundary channel: valid/ready with one boundary flag per codepoint
// ----------------------------------------------------------------------------
interface gcb_out_if;
    logic valid;
    logic ready;
    logic boundary_before;

    modport source (output valid, output boundary_before, input ready);
    modport sink   (input valid, input boundary_before, output ready);
endinterface

### src/grapheme_cluster_boundary.sv
// ----------------------------------------------------------------------------
// grapheme_cluster_boundary
// extended grapheme cluster boundary detector, while o_out is ready one codepoint per cycle
// ----------------------------------------------------------------------------
// usage:
//   i_in  takes one pre-classified codepoint per transaction (break class,
//         conjunct class, text start flag).
//   o_out gives one transaction per codepoint, in order: boundary_before is
//         high when a cluster boundary lies before that codepoint.
//   path: a codepoint accepted on i_in passes the input register, then the
//         result register, before it is offered on o_out.
//   throughput: one codepoint per cycle, sustained while o_out is ready; the
//         rules are a single pass of compares on the class codes and the context register.
//   stall: when o_out is held, the result register keeps its transaction,
//         the input register fills and then i_in.ready drops; nothing is
//         lost or repeated.
//   reset: i_rst_n (synchronous, active low) empties both registers and sets
//         the context to "previous class other", all flags clear.
//   text_start forces a boundary and restarts the context at that codepoint.
// ----------------------------------------------------------------------------
module grapheme_cluster_boundary (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcb_in_if.sink     i_in,
    gcb_out_if.source  o_out
);
    import gcb_pkg::*;

    logic               r_s1_valid;
    logic [CLASS_W-1:0] r_s1_class;
    logic [CONJ_W-1:0]  r_s1_conj;
    logic               r_s1_start;

    logic               r_out_valid;
    logic               r_out_boundary;

    t_gcb_state         r_state;
    t_gcb_state         n_state;
    t_gcb_state         ctx;

    logic               s1_move;
    logic               in_take;
    logic [CLASS_W-1:0] cur;
    logic               is_ctl_p;
    logic               is_ctl_c;
    logic               join_pair;
    logic               n_boundary;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_move;
    assign in_take     = i_in.valid && i_in.ready;

    // unused code folds to other
    assign cur = (r_s1_class > GC_PICT) ? GC_OTHER : r_s1_class;

    // text start works against a cleared context
    assign ctx = r_s1_start ? GCB_STATE_RESET : r_state;

    always_comb begin
        is_ctl_p = (ctx.prior_class == GC_CR) || (ctx.prior_class == GC_LF)
                || (ctx.prior_class == GC_CONTROL);
        is_ctl_c = (cur == GC_CR) || (cur == GC_LF) || (cur == GC_CONTROL);
        join_pair = 1'b0;
        if (ctx.prior_class == GC_CR && cur == GC_LF) begin
            join_pair = 1'b1;
        end else if (is_ctl_p || is_ctl_c) begin
            join_pair = 1'b0;
        end else if (ctx.prior_class == GC_L && (cur == GC_L || cur == GC_V
                     || cur == GC_LV || cur == GC_LVT)) begin
            join_pair = 1'b1;
        end else if ((ctx.prior_class == GC_LV || ctx.prior_class == GC_V)
                     && (cur == GC_V || cur == GC_T)) begin
            join_pair = 1'b1;
        end else if ((ctx.prior_class == GC_LVT || ctx.prior_class == GC_T)
                     && cur == GC_T) begin
            join_pair = 1'b1;
        end else if (ctx.consonant_seen && ctx.linker_after_consonant
                     && r_s1_conj == IC_CONSONANT) begin
            join_pair = 1'b1;
        end else if (cur == GC_EXTEND || cur == GC_ZWJ || cur == GC_SPACING) begin
            join_pair = 1'b1;
        end else if (ctx.prior_class == GC_PREPEND) begin
            join_pair = 1'b1;
        end else if (ctx.pictograph_open && ctx.prior_class == GC_ZWJ
                     && cur == GC_PICT) begin
            join_pair = 1'b1;
        end else if (ctx.prior_class == GC_RI && cur == GC_RI
                     && ctx.indicator_run_odd) begin
            join_pair = 1'b1;
        end
        n_boundary = r_s1_start || !join_pair;
    end

    // context update
    always_comb begin
        n_state = ctx;
        n_state.prior_class = cur;

        if (cur == GC_RI) begin
            n_state.indicator_run_odd = (ctx.prior_class == GC_RI)
                                      ? !ctx.indicator_run_odd : 1'b1;
        end else begin
            n_state.indicator_run_odd = 1'b0;
        end

        if (cur == GC_PICT) begin
            n_state.pictograph_open = 1'b1;
        end else if (cur == GC_EXTEND || cur == GC_ZWJ) begin
            n_state.pictograph_open = ctx.pictograph_open
                                   && (ctx.prior_class != GC_ZWJ);
        end else begin
            n_state.pictograph_open = 1'b0;
        end

        case (r_s1_conj)
            IC_CONSONANT: begin
                n_state.consonant_seen         = 1'b1;
                n_state.linker_after_consonant = 1'b0;
            end
            IC_LINKER: begin
                if (ctx.consonant_seen) begin
                    n_state.linker_after_consonant = 1'b1;
                end
            end
            IC_EXTEND: begin
            end
            default: begin
                n_state.consonant_seen         = 1'b0;
                n_state.linker_after_consonant = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= GCB_STATE_RESET;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_class <= i_in.break_class;
            r_s1_conj  <= i_in.conjunct_class;
            r_s1_start <= i_in.text_start;
        end
        if (s1_move) begin
            r_out_boundary <= n_boundary;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.boundary_before = r_out_boundary;

`ifndef SYNTHESIS
    a_start_breaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_start) |=> (r_out_valid && r_out_boundary))
        else $error("text start did not produce a boundary");

    a_linker_needs_consonant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.linker_after_consonant |-> r_state.consonant_seen)
        else $error("linker flag set without consonant");

    a_ri_run_context: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.indicator_run_odd |-> (r_state.prior_class == GC_RI))
        else $error("indicator parity set after non-indicator");

    a_move_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("result register not loaded");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !s1_move)
        else $error("stalled result overwritten");
`endif

endmodule

### dv/tb_grapheme_cluster_boundary.sv
// ----------------------------------------------------------------------------
// tb_grapheme_cluster_boundary
// self-checking bench for the grapheme cluster boundary detector
// ----------------------------------------------------------------------------
// a short table of hand-picked codepoints walks CR LF, controls, hangul, emoji
// zwj sequences, regional indicators, prepend, spacing marks and indic
// consonant joining; then streams of random clusters and noise run under
// several idle/stall mixes plus one long output hold-off. every boundary flag
// is checked in order against a typed-in flag or a cycle-free rule model.
// ----------------------------------------------------------------------------
module tb_grapheme_cluster_boundary;
    import gcb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [CLASS_W-1:0] break_class;
        logic [CONJ_W-1:0]  conjunct_class;
        logic               text_start;
        bit                 fixed;
        logic               boundary;
    } t_codepoint;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gcb_in_if  codepoint_if ();
    gcb_out_if boundary_if ();

    grapheme_cluster_boundary dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (codepoint_if),
        .o_out   (boundary_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // fixed column marks rows whose flag is typed in
    t_codepoint directed_rows [25] = '{
        '{GC_OTHER,   IC_NONE,      1'b1, 1'b1, 1'b1},
        '{GC_CR,      IC_NONE,      1'b0, 1'b1, 1'b1},
        '{GC_LF,      IC_NONE,      1'b0, 1'b1, 1'b0},
        '{GC_CONTROL, IC_NONE,      1'b0, 1'b1, 1'b1},
        '{GC_EXTEND,  IC_EXTEND,    1'b0, 1'b1, 1'b1},
        '{GC_PICT,    IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_EXTEND,  IC_EXTEND,    1'b0, 1'b0, 1'b0},
        '{GC_ZWJ,     IC_EXTEND,    1'b0, 1'b0, 1'b0},
        '{GC_PICT,    IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_ZWJ,     IC_EXTEND,    1'b0, 1'b0, 1'b0},
        '{GC_ZWJ,     IC_EXTEND,    1'b0, 1'b0, 1'b0},
        '{GC_PICT,    IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_L,       IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_V,       IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_T,       IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_LVT,     IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_RI,      IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_RI,      IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_RI,      IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_PREPEND, IC_NONE,      1'b0, 1'b0, 1'b0},
        '{GC_SPACING, IC_EXTEND,    1'b0, 1'b0, 1'b0},
        '{GC_OTHER,   IC_CONSONANT, 1'b0, 1'b0, 1'b0},
        '{GC_EXTEND,  IC_LINKER,    1'b0, 1'b0, 1'b0},
        '{GC_OTHER,   IC_CONSONANT, 1'b0, 1'b0, 1'b0},
        '{4'd15,      IC_LINKER,    1'b1, 1'b1, 1'b1}
    };

    t_codepoint  stimulus_q [$];
    logic        pending_boundary_q [$];
    t_codepoint  on_bus;
    t_gcb_state  cluster_ctx = GCB_STATE_RESET;

    int unsigned idle_pct       = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_off_left  = 0;
    int unsigned queued_count   = 0;
    int unsigned text_starts    = 0;
    int unsigned accepted_count = 0;
    int unsigned results_seen   = 0;
    int unsigned boundaries     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        predicted;
    logic        wanted;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] boundary check: %s", cycle_count, what);
    endtask

    function automatic bit is_control(input logic [CLASS_W-1:0] k);
        return k == GC_CR || k == GC_LF || k == GC_CONTROL;
    endfunction

    // boundary before this codepoint, then fold the codepoint into the context
    function automatic logic next_boundary(input logic [CLASS_W-1:0] raw_class,
                                           input logic [CONJ_W-1:0]  conj,
                                           input logic               start);
        logic [CLASS_W-1:0] c;
        logic [CLASS_W-1:0] p;
        logic               joined;
        c = (raw_class > GC_PICT) ? GC_OTHER : raw_class;
        if (start) cluster_ctx = GCB_STATE_RESET;
        p = cluster_ctx.prior_class;

        if (start)
            joined = 1'b0;
        else if (p == GC_CR && c == GC_LF)
            joined = 1'b1;
        else if (is_control(p) || is_control(c))
            joined = 1'b0;
        else if (p == GC_L && (c == GC_L || c == GC_V || c == GC_LV || c == GC_LVT))
            joined = 1'b1;
        else if ((p == GC_LV || p == GC_V) && (c == GC_V || c == GC_T))
            joined = 1'b1;
        else if ((p == GC_LVT || p == GC_T) && c == GC_T)
            joined = 1'b1;
        else if (cluster_ctx.consonant_seen && cluster_ctx.linker_after_consonant
                 && conj == IC_CONSONANT)
            joined = 1'b1;
        else if (c == GC_EXTEND || c == GC_ZWJ || c == GC_SPACING)
            joined = 1'b1;
        else if (p == GC_PREPEND)
            joined = 1'b1;
        else if (cluster_ctx.pictograph_open && p == GC_ZWJ && c == GC_PICT)
            joined = 1'b1;
        else if (p == GC_RI && c == GC_RI && cluster_ctx.indicator_run_odd)
            joined = 1'b1;
        else
            joined = 1'b0;

        if (c == GC_RI)
            cluster_ctx.indicator_run_odd = (p == GC_RI) ? !cluster_ctx.indicator_run_odd : 1'b1;
        else
            cluster_ctx.indicator_run_odd = 1'b0;

        if (c == GC_PICT)
            cluster_ctx.pictograph_open = 1'b1;
        else if (c == GC_EXTEND || c == GC_ZWJ)
            cluster_ctx.pictograph_open = cluster_ctx.pictograph_open && p != GC_ZWJ;
        else
            cluster_ctx.pictograph_open = 1'b0;

        if (conj == IC_CONSONANT) begin
            cluster_ctx.consonant_seen         = 1'b1;
            cluster_ctx.linker_after_consonant = 1'b0;
        end else if (conj == IC_LINKER) begin
            if (cluster_ctx.consonant_seen) cluster_ctx.linker_after_consonant = 1'b1;
        end else if (conj != IC_EXTEND) begin
            cluster_ctx.consonant_seen         = 1'b0;
            cluster_ctx.linker_after_consonant = 1'b0;
        end

        cluster_ctx.prior_class = c;
        return !joined;
    endfunction

    task automatic push_codepoint(input logic [CLASS_W-1:0] cls,
                                  input logic [CONJ_W-1:0]  conj,
                                  input logic               start);
        t_codepoint cp;
        cp.break_class    = cls;
        cp.conjunct_class = conj;
        cp.text_start     = start;
        cp.fixed          = 1'b0;
        cp.boundary       = 1'b0;
        stimulus_q.push_back(cp);
        queued_count++;
        if (start) text_starts++;
    endtask

    // mostly well-formed clusters with random content, the rest noise
    task automatic queue_text(input int unsigned count);
        int unsigned        stop_at;
        logic               start;
        logic [CLASS_W-1:0] jamo [5];
        jamo    = '{GC_L, GC_V, GC_T, GC_LV, GC_LVT};
        stop_at = queued_count + count;
        while (queued_count < stop_at) begin
            start = ($urandom_range(24) == 0);
            case ($urandom_range(9))
                0: begin
                    repeat ($urandom_range(5, 1)) begin
                        push_codepoint(jamo[$urandom_range(4)], IC_NONE, start);
                        start = 1'b0;
                    end
                end
                1: begin
                    push_codepoint(GC_PICT, IC_NONE, start);
                    repeat ($urandom_range(2)) push_codepoint(GC_EXTEND, IC_EXTEND, 1'b0);
                    push_codepoint(GC_ZWJ, IC_EXTEND, 1'b0);
                    if ($urandom_range(3) == 0)
                        push_codepoint($urandom_range(1) ? GC_ZWJ : GC_EXTEND, IC_EXTEND, 1'b0);
                    push_codepoint(GC_PICT, IC_NONE, 1'b0);
                end
                2: begin
                    repeat ($urandom_range(5, 1)) begin
                        push_codepoint(GC_RI, IC_NONE, start);
                        start = 1'b0;
                    end
                end
                3: begin
                    push_codepoint(GC_OTHER, IC_CONSONANT, start);
                    repeat ($urandom_range(3))
                        push_codepoint(GC_EXTEND, $urandom_range(1) ? IC_LINKER : IC_EXTEND,
                                       1'b0);
                    push_codepoint($urandom_range(1) ? GC_OTHER : GC_CONTROL, IC_CONSONANT,
                                   1'b0);
                end
                4: begin
                    push_codepoint(GC_CR, CONJ_W'($urandom_range(3)), start);
                    push_codepoint($urandom_range(1) ? GC_LF : GC_CONTROL,
                                   CONJ_W'($urandom_range(3)), 1'b0);
                end
                5: begin
                    push_codepoint(GC_PREPEND, CONJ_W'($urandom_range(3)), start);
                    push_codepoint($urandom_range(1) ? GC_OTHER : GC_SPACING,
                                   CONJ_W'($urandom_range(3)), 1'b0);
                end
                default: push_codepoint(CLASS_W'($urandom_range(15)),
                                        CONJ_W'($urandom_range(3)), start);
            endcase
        end
    endtask

    // wait until every queued codepoint is in and every flag is out
    task automatic drain();
        do @(negedge i_clk);
        while (stimulus_q.size() != 0 || codepoint_if.valid || pending_boundary_q.size() != 0);
    endtask

    task automatic run_phase(input int unsigned count, input int unsigned idle,
                             input int unsigned stall);
        @(negedge i_clk);
        idle_pct  = idle;
        stall_pct = stall;
        queue_text(count);
        drain();
    endtask

    // codepoint source, with prediction on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            codepoint_if.valid <= 1'b0;
        end else begin
            if (codepoint_if.valid && codepoint_if.ready) begin
                predicted = next_boundary(on_bus.break_class, on_bus.conjunct_class,
                                          on_bus.text_start);
                pending_boundary_q.push_back(on_bus.fixed ? on_bus.boundary : predicted);
                accepted_count++;
            end
            if (!codepoint_if.valid || codepoint_if.ready) begin
                if (stimulus_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    on_bus = stimulus_q.pop_front();
                    codepoint_if.valid          <= 1'b1;
                    codepoint_if.break_class    <= on_bus.break_class;
                    codepoint_if.conjunct_class <= on_bus.conjunct_class;
                    codepoint_if.text_start     <= on_bus.text_start;
                end else begin
                    codepoint_if.valid <= 1'b0;
                end
            end
        end
    end

    // boundary sink and compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            boundary_if.ready <= 1'b0;
        end else begin
            if (boundary_if.valid && boundary_if.ready) begin
                results_seen++;
                if (boundary_if.boundary_before === 1'b1) boundaries++;
                if (pending_boundary_q.size() == 0) begin
                    report_mismatch("flag arrived with no codepoint outstanding");
                end else begin
                    wanted = pending_boundary_q.pop_front();
                    if (boundary_if.boundary_before !== wanted)
                        report_mismatch($sformatf("result %0d boundary_before %b, want %b",
                                                  results_seen, boundary_if.boundary_before,
                                                  wanted));
                end
            end
            if (hold_off_left != 0) begin
                boundary_if.ready <= 1'b0;
                hold_off_left--;
            end else begin
                boundary_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n                     = 1'b0;
        codepoint_if.valid          = 1'b0;
        codepoint_if.break_class    = GC_OTHER;
        codepoint_if.conjunct_class = IC_NONE;
        codepoint_if.text_start     = 1'b0;
        boundary_if.ready           = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            stimulus_q.push_back(directed_rows[k]);
            if (directed_rows[k].text_start) text_starts++;
        end
        drain();

        run_phase(200, 0, 0);
        run_phase(200, 57, 0);
        run_phase(200, 0, 57);
        run_phase(200, 28, 28);

        // long output hold-off while codepoints keep coming
        @(negedge i_clk);
        hold_off_left = 80;
        run_phase(100, 0, 0);

        repeat (10) @(posedge i_clk);
        if (pending_boundary_q.size() != 0)
            report_mismatch($sformatf("%0d flags never arrived", pending_boundary_q.size()));

        $display("run covered %0d codepoints (%0d text starts), %0d flags checked, %0d set",
                 accepted_count, text_starts, results_seen, boundaries);
        $display("phases: directed, free-running, source idle, sink stall, both, long hold");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
